// ===== hw/rtl/skyline_atlas_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Skyline atlas allocator assertion macros
// Shared property forms for the checker; clk and rst come from the user scope.
// ----------------------------------------------------------------------------
`ifndef SKYLINE_ATLAS_ALLOCATOR_UNIT_DEFINES_SVH
`define SKYLINE_ATLAS_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SAA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("saa: same-cycle property failed");

// Next-cycle implication.
`define SAA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("saa: next-cycle property failed");

`endif

// ===== hw/rtl/saa_pkg.sv =====
// ----------------------------------------------------------------------------
// saa_pkg
// Request and result types, action codes and scan control for the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package saa_pkg;

  localparam int RECT_W = 8;
  localparam int POS_W  = 7;
  localparam int USED_W = 8;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic              action;
    logic [RECT_W-1:0] rect_width;
    logic [RECT_W-1:0] rect_height;
  } saa_req_t;

  typedef struct packed {
    logic              ok;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [USED_W-1:0] used_height;
  } saa_rsp_t;

  // Control from the sequencer to the window scan unit.
  typedef struct packed {
    logic suf_init;   // restart the block phase counter
    logic suf_step;   // right-to-left pass: column data valid
    logic pre_step;   // left-to-right pass: column and suffix data valid
    logic blk_first;  // data belongs to column zero
    logic win_ok;     // a whole window ends at this column
    logic win_first;  // first window of the pass
  } saa_scan_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/saa_window_unit.sv =====
// ----------------------------------------------------------------------------
// saa_window_unit
// Sliding-window maximum over the skyline in two passes: block suffix maxima
// right to left, then block prefix maxima left to right, keeping the lowest
// window top and its leftmost position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module saa_window_unit import saa_pkg::*; #(
  parameter int AW = 7,
  parameter int CW = 8,
  parameter int HW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  saa_scan_ctl_t ctl,
  input  logic [CW-1:0] rw,
  input  logic [HW-1:0] col_h,
  input  logic [HW-1:0] suf_h,
  input  logic [AW-1:0] win_x,
  output logic [HW-1:0] suf_val,
  output logic [HW-1:0] best,
  output logic [AW-1:0] best_x
);

  logic [HW-1:0] run;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_pre;
  logic [CW-1:0] rw_m1;
  logic          restart;
  logic [HW-1:0] run_max;
  logic [HW-1:0] run_new;
  logic [HW-1:0] win;

  // cnt is the distance to the right end of the column's block, modulo rw
  assign rw_m1   = rw - CW'(1);
  assign cnt_pre = (cnt == '0) ? rw_m1 : cnt - CW'(1);
  assign restart = ctl.suf_step ? (cnt == '0) : (ctl.blk_first || (cnt_pre == rw_m1));

  // shared max unit: running suffix in the first pass, running prefix in the second
  assign run_max = (col_h > run) ? col_h : run;
  assign run_new = restart ? col_h : run_max;
  assign suf_val = run_new;
  assign win     = (suf_h > run_new) ? suf_h : run_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.suf_init) begin
      cnt <= '0;
    end else if (ctl.suf_step) begin
      run <= run_new;
      cnt <= (cnt == rw_m1) ? '0 : cnt + CW'(1);
    end else if (ctl.pre_step) begin
      run <= run_new;
      cnt <= cnt_pre;
      // strict compare keeps the leftmost of equal windows
      if (ctl.win_ok && (ctl.win_first || (win < best))) begin
        best   <= win;
        best_x <= win_x;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/skyline_atlas_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// skyline_atlas_allocator_unit
// Skyline rectangle allocator for a fixed texture atlas.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done and must be captured then, as the block
// cannot be stalled. For an allocate request the column height memory, with
// one read port, is swept once right to left and once left to right, then the
// chosen columns are written one per cycle. A rejected allocate (zero size or
// wider than the atlas) answers in the cycle after it is taken, and a failed
// fit after the two sweeps. A clear request zeroes the column heights. After
// reset the block likewise zeroes the column heights with busy high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skyline_atlas_allocator_unit import saa_pkg::*; #(
  parameter int ATLAS_WIDTH  = 128,
  parameter int ATLAS_HEIGHT = 128
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  saa_req_t req,
  output logic     busy,
  output logic     done,
  output saa_rsp_t result
);

  localparam int AW = $clog2(ATLAS_WIDTH);
  localparam int CW = AW + 1;
  localparam int HW = $clog2(ATLAS_HEIGHT + 1);
  localparam int SW = ((HW > RECT_W) ? HW : RECT_W) + 1;
  localparam logic [CW-1:0] LAST_COL = CW'(ATLAS_WIDTH - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_WIPE  = 6'b000010,
    ST_SUF   = 6'b000100,
    ST_PRE   = 6'b001000,
    ST_CHECK = 6'b010000,
    ST_FILL  = 6'b100000
  } state_t;

  state_t            state;
  logic [CW-1:0]     idx;
  logic              iss_on;
  logic              dv;
  logic [CW-1:0]     dk;
  logic [CW-1:0]     rw_q;
  logic [RECT_W-1:0] rh_q;
  logic [CW-1:0]     left;
  logic              emit_clear;
  logic [HW-1:0]     max_height;
  logic [HW-1:0]     top_q;

  logic [HW-1:0] col_mem [ATLAS_WIDTH];
  logic [HW-1:0] suf_mem [ATLAS_WIDTH];
  logic [HW-1:0] col_rd;
  logic [HW-1:0] suf_rd;

  logic          col_we;
  logic [HW-1:0] col_wd;
  logic          suf_we;
  logic [CW-1:0] suf_ra_full;
  logic [CW-1:0] win_x_full;
  logic [HW-1:0] suf_val;
  logic [HW-1:0] best;
  logic [AW-1:0] best_x;
  logic [SW-1:0] sum;
  logic          fits;
  logic          bad_req;
  saa_scan_ctl_t ctl;

  assign busy = (state != ST_IDLE);

  assign suf_ra_full = idx + CW'(1) - rw_q;
  assign win_x_full  = dk + CW'(1) - rw_q;

  assign col_we = (state == ST_WIPE) || (state == ST_FILL);
  assign col_wd = (state == ST_FILL) ? top_q : '0;
  assign suf_we = (state == ST_SUF) && dv;

  assign sum  = SW'(best) + SW'(rh_q);
  assign fits = (sum <= SW'(ATLAS_HEIGHT));

  assign bad_req = (req.rect_width == '0) || (req.rect_height == '0) ||
                   (int'(req.rect_width) > ATLAS_WIDTH);

  always_comb begin
    ctl.suf_init  = (state == ST_IDLE);
    ctl.suf_step  = (state == ST_SUF) && dv;
    ctl.pre_step  = (state == ST_PRE) && dv;
    ctl.blk_first = (dk == '0);
    ctl.win_ok    = ((dk + CW'(1)) >= rw_q);
    ctl.win_first = ((dk + CW'(1)) == rw_q);
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[idx[AW-1:0]] <= col_wd;
    end
    col_rd <= col_mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (suf_we) begin
      suf_mem[dk[AW-1:0]] <= suf_val;
    end
    suf_rd <= suf_mem[suf_ra_full[AW-1:0]];
  end

  saa_window_unit #(
    .AW (AW),
    .CW (CW),
    .HW (HW)
  ) u_saa_window_unit (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rw      (rw_q),
    .col_h   (col_rd),
    .suf_h   (suf_rd),
    .win_x   (win_x_full[AW-1:0]),
    .suf_val (suf_val),
    .best    (best),
    .best_x  (best_x)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_WIPE;
      idx        <= '0;
      iss_on     <= 1'b0;
      dv         <= 1'b0;
      emit_clear <= 1'b0;
      max_height <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            rw_q <= CW'(req.rect_width);
            rh_q <= req.rect_height;
            if (req.action == ACT_CLEAR) begin
              state      <= ST_WIPE;
              idx        <= '0;
              emit_clear <= 1'b1;
              max_height <= '0;
            end else if (bad_req) begin
              done               <= 1'b1;
              result.ok          <= 1'b0;
              result.pos_x       <= '0;
              result.pos_y       <= '0;
              result.used_height <= USED_W'(max_height);
            end else begin
              state  <= ST_SUF;
              idx    <= LAST_COL;
              iss_on <= 1'b1;
              dv     <= 1'b0;
            end
          end
        end
        ST_WIPE: begin
          if (idx == LAST_COL) begin
            state <= ST_IDLE;
            if (emit_clear) begin
              done               <= 1'b1;
              result.ok          <= 1'b1;
              result.pos_x       <= '0;
              result.pos_y       <= '0;
              result.used_height <= '0;
            end
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ST_SUF: begin
          dv <= iss_on;
          dk <= idx;
          if (iss_on) begin
            if (idx == '0) begin
              iss_on <= 1'b0;
            end else begin
              idx <= idx - CW'(1);
            end
          end
          // hand over to the left-to-right pass once column zero is in
          if (dv && (dk == '0)) begin
            state  <= ST_PRE;
            idx    <= '0;
            iss_on <= 1'b1;
            dv     <= 1'b0;
          end
        end
        ST_PRE: begin
          dv <= iss_on;
          dk <= idx;
          if (iss_on) begin
            if (idx == LAST_COL) begin
              iss_on <= 1'b0;
            end else begin
              idx <= idx + CW'(1);
            end
          end
          if (dv && (dk == LAST_COL)) begin
            state <= ST_CHECK;
            dv    <= 1'b0;
          end
        end
        ST_CHECK: begin
          if (fits) begin
            state <= ST_FILL;
            top_q <= HW'(sum);
            idx   <= CW'(best_x);
            left  <= rw_q;
            if (HW'(sum) > max_height) begin
              max_height <= HW'(sum);
            end
          end else begin
            state              <= ST_IDLE;
            done               <= 1'b1;
            result.ok          <= 1'b0;
            result.pos_x       <= '0;
            result.pos_y       <= '0;
            result.used_height <= USED_W'(max_height);
          end
        end
        ST_FILL: begin
          idx  <= idx + CW'(1);
          left <= left - CW'(1);
          if (left == CW'(1)) begin
            state              <= ST_IDLE;
            done               <= 1'b1;
            result.ok          <= 1'b1;
            result.pos_x       <= POS_W'(best_x);
            result.pos_y       <= POS_W'(best);
            result.used_height <= USED_W'(max_height);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/saa_checker.sv =====
// ----------------------------------------------------------------------------
// saa_checker
// Port-level properties of the skyline atlas allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "skyline_atlas_allocator_unit_defines.svh"

module saa_checker import saa_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire saa_req_t req,
  input wire logic     busy,
  input wire logic     done,
  input wire saa_rsp_t result
);

  logic zero_alloc;
  logic fail_pos_zero;

  assign zero_alloc = start && !busy && (req.action == ACT_ALLOC) &&
                      ((req.rect_width == '0) || (req.rect_height == '0));
  assign fail_pos_zero = (result.pos_x == '0) && (result.pos_y == '0);

  // a result strobe coincides with the block becoming free again
  `SAA_ASSERT_SAME(a_done_idle, done, !busy)

  // a failed request reports no position
  `SAA_ASSERT_SAME(a_fail_zero, done && !result.ok, fail_pos_zero)

  // a zero-sized allocate is rejected on the next cycle
  `SAA_ASSERT_NEXT(a_zero_reject, zero_alloc, done && !result.ok)

  // a clear request occupies the block while the heights are swept
  `SAA_ASSERT_NEXT(a_clear_busy, start && !busy && (req.action == ACT_CLEAR), busy && !done)

endmodule

bind skyline_atlas_allocator_unit saa_checker u_saa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .req    (req),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

// ===== sim/tb_skyline_atlas_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_skyline_atlas_allocator_unit
// Self-checking bench for the skyline atlas allocator.
// ----------------------------------------------------------------------------
// Directed requests cover rejected sizes, full-height and full-width placements,
// the rightmost window, ties and clears. Random allocate and clear requests
// follow, with random gaps between requests. Each result is compared against
// a local skyline that mirrors the column heights of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_skyline_atlas_allocator_unit;
  import saa_pkg::*;

  localparam int ATLAS_W      = 128;
  localparam int ATLAS_H      = 128;
  localparam int RANDOM_REQS  = 480;
  localparam int DRAIN_CYCLES = 3 * ATLAS_W + 16;
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic     clk   = 1'b0;
  logic     rst   = 1'b1;
  logic     start = 1'b0;
  saa_req_t req   = '0;
  logic     busy;
  logic     done;
  saa_rsp_t result;

  // Filled height of every column, as the block should hold it.
  int       skyline [ATLAS_W];
  saa_req_t pending_reqs [$];
  saa_rsp_t expected_rsps [$];

  int total_reqs     = 0;
  int accepted_count = 0;
  int checked_count  = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int placed_count   = 0;
  int refused_count  = 0;
  int clear_count    = 0;
  int idle_left      = 0;
  int gap_roll;

  skyline_atlas_allocator_unit #(
    .ATLAS_WIDTH  (ATLAS_W),
    .ATLAS_HEIGHT (ATLAS_H)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // Apply one request to the local skyline and return the answer it should give.
  function automatic saa_rsp_t place_on_skyline(saa_req_t r);
    saa_rsp_t rsp;
    int       w;
    int       h;
    int       top;
    int       best;
    int       best_x;
    int       tallest;
    rsp    = '0;
    w      = r.rect_width;
    h      = r.rect_height;
    best   = ATLAS_H + 1;
    best_x = 0;
    if (r.action == ACT_CLEAR) begin
      for (int c = 0; c < ATLAS_W; c++) skyline[c] = 0;
      rsp.ok = 1'b1;
      clear_count++;
    end else if (w == 0 || h == 0 || w > ATLAS_W) begin
      refused_count++;
    end else begin
      // strict compare keeps the leftmost of equally low windows
      for (int x = 0; x + w <= ATLAS_W; x++) begin
        top = 0;
        for (int c = x; c < x + w; c++) begin
          if (skyline[c] > top) top = skyline[c];
        end
        if (top < best) begin
          best   = top;
          best_x = x;
        end
      end
      if (best + h > ATLAS_H) begin
        refused_count++;
      end else begin
        for (int c = best_x; c < best_x + w; c++) skyline[c] = best + h;
        rsp.ok    = 1'b1;
        rsp.pos_x = POS_W'(best_x);
        rsp.pos_y = POS_W'(best);
        placed_count++;
      end
    end
    tallest = 0;
    for (int c = 0; c < ATLAS_W; c++) begin
      if (skyline[c] > tallest) tallest = skyline[c];
    end
    rsp.used_height = USED_W'(tallest);
    return rsp;
  endfunction

  task automatic add_request(input logic act, input int w, input int h);
    saa_req_t r;
    r.action      = act;
    r.rect_width  = RECT_W'(w);
    r.rect_height = RECT_W'(h);
    pending_reqs.push_back(r);
  endtask

  // Driver: present queued requests, predict on acceptance, idle at random.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_rsps.push_back(place_on_skyline(req));
      accepted_count++;
      gap_roll = $urandom_range(0, 99);
      if (gap_roll < 60) begin
        idle_left = 0;
      end else if (gap_roll < 85) begin
        idle_left = $urandom_range(1, 4);
      end else if (gap_roll < 97) begin
        idle_left = $urandom_range(5, 40);
      end else begin
        idle_left = $urandom_range(100, 400);
      end
      // hold start high when the next request follows at once
      if (idle_left == 0 && pending_reqs.size() != 0) begin
        req <= pending_reqs.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (idle_left > 0) begin
        idle_left--;
      end else if (pending_reqs.size() != 0) begin
        start <= 1'b1;
        req   <= pending_reqs.pop_front();
      end
    end
  end

  // Monitor: every done cycle carries a result that must match the oldest request.
  always @(posedge clk) begin
    saa_rsp_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_rsps.size());
      $display("skyline_atlas_allocator_unit verification failed");
      $finish;
    end else if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        if (error_count < 10) begin
          $display("unexpected result: ok=%0b x=%0d y=%0d used=%0d",
                   result.ok, result.pos_x, result.pos_y, result.used_height);
        end
        error_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (result.ok !== want.ok || result.pos_x !== want.pos_x ||
            result.pos_y !== want.pos_y || result.used_height !== want.used_height) begin
          if (error_count < 10) begin
            $display("mismatch on result %0d: expected ok=%0b x=%0d y=%0d used=%0d",
                     checked_count, want.ok, want.pos_x, want.pos_y, want.used_height);
            $display("  got ok=%0b x=%0d y=%0d used=%0d",
                     result.ok, result.pos_x, result.pos_y, result.used_height);
          end
          error_count++;
        end
        checked_count++;
      end
    end
  end

  initial begin
    int pick;

    // rejected sizes
    add_request(ACT_ALLOC, 0, 5);
    add_request(ACT_ALLOC, 5, 0);
    add_request(ACT_ALLOC, 129, 1);
    add_request(ACT_ALLOC, 255, 255);
    // whole atlas in one request, then no room left
    add_request(ACT_ALLOC, 128, 128);
    add_request(ACT_ALLOC, 1, 1);
    add_request(ACT_CLEAR, 255, 255);
    // rightmost window must be reachable
    add_request(ACT_ALLOC, 127, 5);
    add_request(ACT_ALLOC, 1, 1);
    add_request(ACT_ALLOC, 1, 3);
    add_request(ACT_ALLOC, 2, 2);
    add_request(ACT_CLEAR, 0, 0);
    // top row reached, then refused
    add_request(ACT_ALLOC, 128, 127);
    add_request(ACT_ALLOC, 128, 1);
    add_request(ACT_ALLOC, 1, 1);
    add_request(ACT_CLEAR, 170, 85);
    // ties between equally low windows
    add_request(ACT_ALLOC, 4, 10);
    add_request(ACT_ALLOC, 4, 10);
    add_request(ACT_ALLOC, 64, 128);
    add_request(ACT_ALLOC, 1, 118);
    add_request(ACT_ALLOC, 8, 119);
    add_request(ACT_ALLOC, 128, 1);
    add_request(ACT_CLEAR, 85, 170);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        add_request(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (pick < 12) begin
        add_request(ACT_ALLOC, $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (pick < 20) begin
        add_request(ACT_ALLOC, $urandom_range(65, 128), $urandom_range(1, 128));
      end else begin
        add_request(ACT_ALLOC, $urandom_range(1, 48), $urandom_range(1, 64));
      end
    end
    total_reqs = pending_reqs.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // check on the falling edge, clear of the driver's updates
    while (!(accepted_count == total_reqs && expected_rsps.size() == 0)) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_rsps.size() != 0) begin
      $display("%0d results never arrived", expected_rsps.size());
      error_count += expected_rsps.size();
    end
    $display("%0d requests sent: %0d rectangles placed, %0d refused, %0d clears",
             accepted_count, placed_count, refused_count, clear_count);
    $display("%0d results checked, %0d errors", checked_count, error_count);
    if (error_count == 0) begin
      $display("skyline_atlas_allocator_unit verification clean");
    end else begin
      $display("skyline_atlas_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
